[design/crtcm_pkg.sv]
// Types, constants and width classification shared by the terminal cell mapper.
package crtcm_pkg;

    localparam int CP_W          = 21;
    localparam int CNT_W         = 12;
    localparam int LINE_CAPACITY = 4096;
    localparam logic [CNT_W-1:0] COUNT_MAX =
        CNT_W'((LINE_CAPACITY - 1 < 4095) ? LINE_CAPACITY - 1 : 4095);

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 24;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [1:0] WIDTH_NONE = 2'd0;
    localparam logic [1:0] WIDTH_ONE  = 2'd1;
    localparam logic [1:0] WIDTH_TWO  = 2'd2;

    typedef struct packed {
        logic [CNT_W-1:0] offset;
        logic [CNT_W-1:0] column;
        logic [CNT_W-1:0] column2;
        logic             wide;
    } cell_entry_t;

    typedef enum logic {
        BK_FIRST,
        BK_SECOND
    } back_state_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        sat_inc = (v >= COUNT_MAX) ? COUNT_MAX : v + CNT_W'(1);
    endfunction

    function automatic logic in_rng(input logic [CP_W-1:0] c,
                                    input logic [CP_W-1:0] lo,
                                    input logic [CP_W-1:0] hi);
        in_rng = (c >= lo) && (c <= hi);
    endfunction

    function automatic logic in_zw_table(input logic [CP_W-1:0] c);
        logic z;
        z = 1'b0;
        z = z | in_rng(c, 21'h00300, 21'h00357) | in_rng(c, 21'h0035D, 21'h0036F);
        z = z | in_rng(c, 21'h00483, 21'h00486) | in_rng(c, 21'h00488, 21'h00489);
        z = z | in_rng(c, 21'h00591, 21'h005A1) | in_rng(c, 21'h005A3, 21'h005B9);
        z = z | in_rng(c, 21'h005BB, 21'h005BD) | in_rng(c, 21'h005BF, 21'h005BF);
        z = z | in_rng(c, 21'h005C1, 21'h005C2) | in_rng(c, 21'h005C4, 21'h005C4);
        z = z | in_rng(c, 21'h00600, 21'h00603) | in_rng(c, 21'h00610, 21'h00615);
        z = z | in_rng(c, 21'h0064B, 21'h00658) | in_rng(c, 21'h00670, 21'h00670);
        z = z | in_rng(c, 21'h006D6, 21'h006E4) | in_rng(c, 21'h006E7, 21'h006E8);
        z = z | in_rng(c, 21'h006EA, 21'h006ED) | in_rng(c, 21'h0070F, 21'h0070F);
        z = z | in_rng(c, 21'h00711, 21'h00711) | in_rng(c, 21'h00730, 21'h0074A);
        z = z | in_rng(c, 21'h007A6, 21'h007B0) | in_rng(c, 21'h00901, 21'h00902);
        z = z | in_rng(c, 21'h0093C, 21'h0093C) | in_rng(c, 21'h00941, 21'h00948);
        z = z | in_rng(c, 21'h0094D, 21'h0094D) | in_rng(c, 21'h00951, 21'h00954);
        z = z | in_rng(c, 21'h00962, 21'h00963) | in_rng(c, 21'h00981, 21'h00981);
        z = z | in_rng(c, 21'h009BC, 21'h009BC) | in_rng(c, 21'h009C1, 21'h009C4);
        z = z | in_rng(c, 21'h009CD, 21'h009CD) | in_rng(c, 21'h009E2, 21'h009E3);
        z = z | in_rng(c, 21'h00A01, 21'h00A02) | in_rng(c, 21'h00A3C, 21'h00A3C);
        z = z | in_rng(c, 21'h00A41, 21'h00A42) | in_rng(c, 21'h00A47, 21'h00A48);
        z = z | in_rng(c, 21'h00A4B, 21'h00A4D) | in_rng(c, 21'h00A70, 21'h00A71);
        z = z | in_rng(c, 21'h00A81, 21'h00A82) | in_rng(c, 21'h00ABC, 21'h00ABC);
        z = z | in_rng(c, 21'h00AC1, 21'h00AC5) | in_rng(c, 21'h00AC7, 21'h00AC8);
        z = z | in_rng(c, 21'h00ACD, 21'h00ACD) | in_rng(c, 21'h00AE2, 21'h00AE3);
        z = z | in_rng(c, 21'h00B01, 21'h00B01) | in_rng(c, 21'h00B3C, 21'h00B3C);
        z = z | in_rng(c, 21'h00B3F, 21'h00B3F) | in_rng(c, 21'h00B41, 21'h00B43);
        z = z | in_rng(c, 21'h00B4D, 21'h00B4D) | in_rng(c, 21'h00B56, 21'h00B56);
        z = z | in_rng(c, 21'h00B82, 21'h00B82) | in_rng(c, 21'h00BC0, 21'h00BC0);
        z = z | in_rng(c, 21'h00BCD, 21'h00BCD) | in_rng(c, 21'h00C3E, 21'h00C40);
        z = z | in_rng(c, 21'h00C46, 21'h00C48) | in_rng(c, 21'h00C4A, 21'h00C4D);
        z = z | in_rng(c, 21'h00C55, 21'h00C56) | in_rng(c, 21'h00CBC, 21'h00CBC);
        z = z | in_rng(c, 21'h00CBF, 21'h00CBF) | in_rng(c, 21'h00CC6, 21'h00CC6);
        z = z | in_rng(c, 21'h00CCC, 21'h00CCD) | in_rng(c, 21'h00D41, 21'h00D43);
        z = z | in_rng(c, 21'h00D4D, 21'h00D4D) | in_rng(c, 21'h00DCA, 21'h00DCA);
        z = z | in_rng(c, 21'h00DD2, 21'h00DD4) | in_rng(c, 21'h00DD6, 21'h00DD6);
        z = z | in_rng(c, 21'h00E31, 21'h00E31) | in_rng(c, 21'h00E34, 21'h00E3A);
        z = z | in_rng(c, 21'h00E47, 21'h00E4E) | in_rng(c, 21'h00EB1, 21'h00EB1);
        z = z | in_rng(c, 21'h00EB4, 21'h00EB9) | in_rng(c, 21'h00EBB, 21'h00EBC);
        z = z | in_rng(c, 21'h00EC8, 21'h00ECD) | in_rng(c, 21'h00F18, 21'h00F19);
        z = z | in_rng(c, 21'h00F35, 21'h00F35) | in_rng(c, 21'h00F37, 21'h00F37);
        z = z | in_rng(c, 21'h00F39, 21'h00F39) | in_rng(c, 21'h00F71, 21'h00F7E);
        z = z | in_rng(c, 21'h00F80, 21'h00F84) | in_rng(c, 21'h00F86, 21'h00F87);
        z = z | in_rng(c, 21'h00F90, 21'h00F97) | in_rng(c, 21'h00F99, 21'h00FBC);
        z = z | in_rng(c, 21'h00FC6, 21'h00FC6) | in_rng(c, 21'h0102D, 21'h01030);
        z = z | in_rng(c, 21'h01032, 21'h01032) | in_rng(c, 21'h01036, 21'h01037);
        z = z | in_rng(c, 21'h01039, 21'h01039) | in_rng(c, 21'h01058, 21'h01059);
        z = z | in_rng(c, 21'h01160, 21'h011FF) | in_rng(c, 21'h01712, 21'h01714);
        z = z | in_rng(c, 21'h01732, 21'h01734) | in_rng(c, 21'h01752, 21'h01753);
        z = z | in_rng(c, 21'h01772, 21'h01773) | in_rng(c, 21'h017B4, 21'h017B5);
        z = z | in_rng(c, 21'h017B7, 21'h017BD) | in_rng(c, 21'h017C6, 21'h017C6);
        z = z | in_rng(c, 21'h017C9, 21'h017D3) | in_rng(c, 21'h017DD, 21'h017DD);
        z = z | in_rng(c, 21'h0180B, 21'h0180D) | in_rng(c, 21'h018A9, 21'h018A9);
        z = z | in_rng(c, 21'h01920, 21'h01922) | in_rng(c, 21'h01927, 21'h01928);
        z = z | in_rng(c, 21'h01932, 21'h01932) | in_rng(c, 21'h01939, 21'h0193B);
        z = z | in_rng(c, 21'h0200B, 21'h0200F) | in_rng(c, 21'h0202A, 21'h0202E);
        z = z | in_rng(c, 21'h02060, 21'h02063) | in_rng(c, 21'h0206A, 21'h0206F);
        z = z | in_rng(c, 21'h020D0, 21'h020EA) | in_rng(c, 21'h0302A, 21'h0302F);
        z = z | in_rng(c, 21'h03099, 21'h0309A) | in_rng(c, 21'h0FB1E, 21'h0FB1E);
        z = z | in_rng(c, 21'h0FE00, 21'h0FE0F) | in_rng(c, 21'h0FE20, 21'h0FE23);
        z = z | in_rng(c, 21'h0FEFF, 21'h0FEFF) | in_rng(c, 21'h0FFF9, 21'h0FFFB);
        z = z | in_rng(c, 21'h1D167, 21'h1D169) | in_rng(c, 21'h1D173, 21'h1D182);
        z = z | in_rng(c, 21'h1D185, 21'h1D18B) | in_rng(c, 21'h1D1AA, 21'h1D1AD);
        z = z | in_rng(c, 21'hE0001, 21'hE0001) | in_rng(c, 21'hE0020, 21'hE007F);
        z = z | in_rng(c, 21'hE0100, 21'hE01EF);
        in_zw_table = z;
    endfunction

    function automatic logic [1:0] cell_width(input logic [CP_W-1:0] c);
        logic wide;
        wide = (c >= 21'h01100) &&
               ((c <= 21'h0115F) ||
                (c == 21'h02329) || (c == 21'h0232A) ||
                (in_rng(c, 21'h02E80, 21'h0A4CF) && (c != 21'h0303F)) ||
                in_rng(c, 21'h0AC00, 21'h0D7A3) ||
                in_rng(c, 21'h0F900, 21'h0FAFF) ||
                in_rng(c, 21'h0FE30, 21'h0FE6F) ||
                in_rng(c, 21'h0FF00, 21'h0FF60) ||
                in_rng(c, 21'h0FFE0, 21'h0FFE6) ||
                in_rng(c, 21'h20000, 21'h2FFFD) ||
                in_rng(c, 21'h30000, 21'h3FFFD));
        if ((c < 21'h00020) || ((c >= 21'h0007F) && (c < 21'h000A0))) begin
            cell_width = WIDTH_NONE;
        end else if (in_zw_table(c)) begin
            cell_width = WIDTH_NONE;
        end else if (wide) begin
            cell_width = WIDTH_TWO;
        end else begin
            cell_width = WIDTH_ONE;
        end
    endfunction

endpackage

[design/crtcm_front.sv]
// Front end: accepts code points, classifies width and advances the line counters.
module crtcm_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [crtcm_pkg::S_TDATA_W-1:0] s_tdata,  // [20:0] code_point
    input  logic                        s_tuser,  // [0] start_of_line
    output logic                        push,
    output crtcm_pkg::cell_entry_t      push_entry,
    input  logic                        full
);

    logic                           stg_valid_reg, stg_valid_next;
    logic [crtcm_pkg::CP_W-1:0]     stg_cp_reg;
    logic                           stg_sol_reg;
    logic [crtcm_pkg::CNT_W-1:0]    char_pos_reg, char_pos_next;
    logic [crtcm_pkg::CNT_W-1:0]    col_pos_reg, col_pos_next;
    logic [1:0]                     width;
    logic [crtcm_pkg::CNT_W-1:0]    char_base, col_base, col2;
    logic                           adv;

    always_comb begin
        width     = crtcm_pkg::cell_width(stg_cp_reg);
        char_base = stg_sol_reg ? '0 : char_pos_reg;
        col_base  = stg_sol_reg ? '0 : col_pos_reg;
        col2      = crtcm_pkg::sat_inc(col_base);
        adv       = stg_valid_reg && ((width == crtcm_pkg::WIDTH_NONE) || !full);
        push      = stg_valid_reg && (width != crtcm_pkg::WIDTH_NONE) && !full;
        s_tready  = !stg_valid_reg || adv;

        push_entry.offset  = char_base;
        push_entry.column  = col_base;
        push_entry.column2 = col2;
        push_entry.wide    = (width == crtcm_pkg::WIDTH_TWO);

        stg_valid_next = s_tready ? s_tvalid : stg_valid_reg;
        char_pos_next  = char_pos_reg;
        col_pos_next   = col_pos_reg;
        if (adv) begin
            char_pos_next = crtcm_pkg::sat_inc(char_base);
            case (width)
                crtcm_pkg::WIDTH_NONE: col_pos_next = col_base;
                crtcm_pkg::WIDTH_ONE:  col_pos_next = col2;
                crtcm_pkg::WIDTH_TWO:  col_pos_next = crtcm_pkg::sat_inc(col2);
                default:               col_pos_next = col_base;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stg_valid_reg <= 1'b0;
            char_pos_reg  <= '0;
            col_pos_reg   <= '0;
        end else begin
            stg_valid_reg <= stg_valid_next;
            char_pos_reg  <= char_pos_next;
            col_pos_reg   <= col_pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            stg_cp_reg  <= s_tdata[crtcm_pkg::CP_W-1:0];
            stg_sol_reg <= s_tuser;
        end
    end

endmodule

[design/crtcm_fifo.sv]
// Short queue of classified cell entries between front and back end.
module crtcm_fifo (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  crtcm_pkg::cell_entry_t push_entry,
    output logic                   full,
    input  logic                   pop,
    output crtcm_pkg::cell_entry_t pop_entry,
    output logic                   empty
);

    crtcm_pkg::cell_entry_t            mem [crtcm_pkg::FIFO_DEPTH];
    logic [crtcm_pkg::FIFO_AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [crtcm_pkg::FIFO_AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [crtcm_pkg::FIFO_AW:0]       count_reg, count_next;

    always_comb begin
        full        = (count_reg == (crtcm_pkg::FIFO_AW+1)'(crtcm_pkg::FIFO_DEPTH));
        empty       = (count_reg == '0);
        pop_entry   = mem[rd_ptr_reg];
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

[design/crtcm_back.sv]
// Back end: expands queued entries into one or two output words.
module crtcm_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    output logic                        pop,
    input  crtcm_pkg::cell_entry_t      pop_entry,
    input  logic                        empty,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [crtcm_pkg::M_TDATA_W-1:0] m_tdata,  // [11:0] source_offset, [23:12] cell_column
    output logic                        m_tuser,  // [0] continuation
    output logic                        m_tlast
);

    crtcm_pkg::back_state_t             state_reg, state_next;
    logic [crtcm_pkg::CNT_W-1:0]        hold_off_reg, hold_col_reg;
    logic                               m_valid_reg, m_valid_next;
    logic [crtcm_pkg::M_TDATA_W-1:0]    m_data_reg, m_data_next;
    logic                               m_user_reg, m_user_next;
    logic                               m_last_reg, m_last_next;
    logic                               load;

    assign load = !m_valid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            crtcm_pkg::BK_FIRST: begin
                if (load && !empty && pop_entry.wide) begin
                    state_next = crtcm_pkg::BK_SECOND;
                end
            end
            crtcm_pkg::BK_SECOND: begin
                if (load) begin
                    state_next = crtcm_pkg::BK_FIRST;
                end
            end
            default: state_next = crtcm_pkg::BK_FIRST;
        endcase
    end

    always_comb begin
        pop          = 1'b0;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        m_last_next  = m_last_reg;
        case (state_reg)
            crtcm_pkg::BK_FIRST: begin
                if (load) begin
                    pop          = !empty;
                    m_valid_next = !empty;
                    m_data_next  = {pop_entry.column, pop_entry.offset};
                    m_user_next  = 1'b0;
                    m_last_next  = !pop_entry.wide;
                end
            end
            crtcm_pkg::BK_SECOND: begin
                if (load) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {hold_col_reg, hold_off_reg};
                    m_user_next  = 1'b1;
                    m_last_next  = 1'b1;
                end
            end
            default: m_valid_next = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= crtcm_pkg::BK_FIRST;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
        m_last_reg <= m_last_next;
        if (pop) begin
            hold_off_reg <= pop_entry.offset;
            hold_col_reg <= pop_entry.column2;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

endmodule

[design/char_to_terminal_cell_mapper_core.sv]
// Top level of the terminal cell mapper: front end, entry queue and back end.
// An accepted word passes the staging register, the entry queue and the output register.
// Throughput: one input word per cycle while the queue has room; one output word per cycle
// while the receiver is ready, so a wide character gives two words and a zero-width one none.
// The four-entry queue between classifier and word expander sets how far they drift.
// Reset: aresetn low at a clock edge clears both line counters and empties the queue.
module char_to_terminal_cell_mapper_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [crtcm_pkg::S_TDATA_W-1:0] s_tdata,  // [20:0] code_point
    input  logic                            s_tuser,  // [0] start_of_line
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [crtcm_pkg::M_TDATA_W-1:0] m_tdata,  // [11:0] source_offset, [23:12] cell_column
    output logic                            m_tuser,  // [0] continuation
    output logic                            m_tlast   // last_entry
);

    logic                   push, full, pop, empty;
    crtcm_pkg::cell_entry_t push_entry, pop_entry;

    crtcm_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .push       (push),
        .push_entry (push_entry),
        .full       (full)
    );

    crtcm_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .full       (full),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .empty      (empty)
    );

    crtcm_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop       (pop),
        .pop_entry (pop_entry),
        .empty     (empty),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

[design/crtcm_checker.sv]
// Port-level checks for the terminal cell mapper, bound to the top level.
module crtcm_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [crtcm_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic                            m_tuser,
    input  logic                            m_tlast
);

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output word changed while stalled");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

    a_cont_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("continuation word not marked last");

    a_wide_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=>
            m_tvalid && m_tuser && (m_tdata[11:0] == $past(m_tdata[11:0])))
        else $error("left half not followed by its continuation");

endmodule

bind char_to_terminal_cell_mapper_core crtcm_checker u_crtcm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

[bench/char_to_terminal_cell_mapper_core_test.sv]
`timescale 1ns / 1ps
// Self-checking bench for the terminal cell mapper: code point words in, screen cell words checked.
module char_to_terminal_cell_mapper_core_test;

    localparam int NZW         = 123;
    localparam int NEDGE       = 51;
    localparam int TAIL_WORDS  = 60;
    localparam int STALL_LIMIT = 4000;
    localparam int LONG_HOLD   = 300;

    localparam logic [0:NZW-1][41:0] ZW_SPANS = {
        21'h00300, 21'h00357, 21'h0035D, 21'h0036F, 21'h00483, 21'h00486,
        21'h00488, 21'h00489, 21'h00591, 21'h005A1, 21'h005A3, 21'h005B9,
        21'h005BB, 21'h005BD, 21'h005BF, 21'h005BF, 21'h005C1, 21'h005C2,
        21'h005C4, 21'h005C4, 21'h00600, 21'h00603, 21'h00610, 21'h00615,
        21'h0064B, 21'h00658, 21'h00670, 21'h00670, 21'h006D6, 21'h006E4,
        21'h006E7, 21'h006E8, 21'h006EA, 21'h006ED, 21'h0070F, 21'h0070F,
        21'h00711, 21'h00711, 21'h00730, 21'h0074A, 21'h007A6, 21'h007B0,
        21'h00901, 21'h00902, 21'h0093C, 21'h0093C, 21'h00941, 21'h00948,
        21'h0094D, 21'h0094D, 21'h00951, 21'h00954, 21'h00962, 21'h00963,
        21'h00981, 21'h00981, 21'h009BC, 21'h009BC, 21'h009C1, 21'h009C4,
        21'h009CD, 21'h009CD, 21'h009E2, 21'h009E3, 21'h00A01, 21'h00A02,
        21'h00A3C, 21'h00A3C, 21'h00A41, 21'h00A42, 21'h00A47, 21'h00A48,
        21'h00A4B, 21'h00A4D, 21'h00A70, 21'h00A71, 21'h00A81, 21'h00A82,
        21'h00ABC, 21'h00ABC, 21'h00AC1, 21'h00AC5, 21'h00AC7, 21'h00AC8,
        21'h00ACD, 21'h00ACD, 21'h00AE2, 21'h00AE3, 21'h00B01, 21'h00B01,
        21'h00B3C, 21'h00B3C, 21'h00B3F, 21'h00B3F, 21'h00B41, 21'h00B43,
        21'h00B4D, 21'h00B4D, 21'h00B56, 21'h00B56, 21'h00B82, 21'h00B82,
        21'h00BC0, 21'h00BC0, 21'h00BCD, 21'h00BCD, 21'h00C3E, 21'h00C40,
        21'h00C46, 21'h00C48, 21'h00C4A, 21'h00C4D, 21'h00C55, 21'h00C56,
        21'h00CBC, 21'h00CBC, 21'h00CBF, 21'h00CBF, 21'h00CC6, 21'h00CC6,
        21'h00CCC, 21'h00CCD, 21'h00D41, 21'h00D43, 21'h00D4D, 21'h00D4D,
        21'h00DCA, 21'h00DCA, 21'h00DD2, 21'h00DD4, 21'h00DD6, 21'h00DD6,
        21'h00E31, 21'h00E31, 21'h00E34, 21'h00E3A, 21'h00E47, 21'h00E4E,
        21'h00EB1, 21'h00EB1, 21'h00EB4, 21'h00EB9, 21'h00EBB, 21'h00EBC,
        21'h00EC8, 21'h00ECD, 21'h00F18, 21'h00F19, 21'h00F35, 21'h00F35,
        21'h00F37, 21'h00F37, 21'h00F39, 21'h00F39, 21'h00F71, 21'h00F7E,
        21'h00F80, 21'h00F84, 21'h00F86, 21'h00F87, 21'h00F90, 21'h00F97,
        21'h00F99, 21'h00FBC, 21'h00FC6, 21'h00FC6, 21'h0102D, 21'h01030,
        21'h01032, 21'h01032, 21'h01036, 21'h01037, 21'h01039, 21'h01039,
        21'h01058, 21'h01059, 21'h01160, 21'h011FF, 21'h01712, 21'h01714,
        21'h01732, 21'h01734, 21'h01752, 21'h01753, 21'h01772, 21'h01773,
        21'h017B4, 21'h017B5, 21'h017B7, 21'h017BD, 21'h017C6, 21'h017C6,
        21'h017C9, 21'h017D3, 21'h017DD, 21'h017DD, 21'h0180B, 21'h0180D,
        21'h018A9, 21'h018A9, 21'h01920, 21'h01922, 21'h01927, 21'h01928,
        21'h01932, 21'h01932, 21'h01939, 21'h0193B, 21'h0200B, 21'h0200F,
        21'h0202A, 21'h0202E, 21'h02060, 21'h02063, 21'h0206A, 21'h0206F,
        21'h020D0, 21'h020EA, 21'h0302A, 21'h0302F, 21'h03099, 21'h0309A,
        21'h0FB1E, 21'h0FB1E, 21'h0FE00, 21'h0FE0F, 21'h0FE20, 21'h0FE23,
        21'h0FEFF, 21'h0FEFF, 21'h0FFF9, 21'h0FFFB, 21'h1D167, 21'h1D169,
        21'h1D173, 21'h1D182, 21'h1D185, 21'h1D18B, 21'h1D1AA, 21'h1D1AD,
        21'hE0001, 21'hE0001, 21'hE0020, 21'hE007F, 21'hE0100, 21'hE01EF
    };

    localparam logic [0:NEDGE-1][crtcm_pkg::CP_W-1:0] EDGE_CODES = {
        21'h0001F, 21'h00020, 21'h0007E, 21'h0007F, 21'h0009F, 21'h000A0, 21'h010FF, 21'h01100,
        21'h0115F, 21'h01160, 21'h02328, 21'h02329, 21'h0232A, 21'h0232B, 21'h02E7F, 21'h02E80,
        21'h0303E, 21'h0303F, 21'h03040, 21'h0A4CF, 21'h0A4D0, 21'h0ABFF, 21'h0AC00, 21'h0D7A3,
        21'h0D7A4, 21'h0F8FF, 21'h0F900, 21'h0FAFF, 21'h0FB00, 21'h0FE2F, 21'h0FE30, 21'h0FE6F,
        21'h0FE70, 21'h0FEFF, 21'h0FF00, 21'h0FF60, 21'h0FF61, 21'h0FFDF, 21'h0FFE0, 21'h0FFE6,
        21'h0FFE7, 21'h1FFFF, 21'h20000, 21'h2FFFD, 21'h2FFFE, 21'h30000, 21'h3FFFD, 21'h3FFFE,
        21'h10FFFF, 21'h110000, 21'h1FFFFF
    };

    typedef struct {
        logic [crtcm_pkg::CP_W-1:0] code;
        logic                       sol;
        bit                         drain;
    } char_word_t;

    typedef struct {
        logic [crtcm_pkg::CNT_W-1:0] offset;
        logic [crtcm_pkg::CNT_W-1:0] column;
        logic                        cont;
        logic                        last;
    } screen_cell_t;

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [crtcm_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic                            s_tuser = 1'b0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [crtcm_pkg::M_TDATA_W-1:0] m_tdata;
    logic                            m_tuser;
    logic                            m_tlast;

    char_word_t                  feed_q[$];
    screen_cell_t                cell_q[$];
    logic [crtcm_pkg::CNT_W-1:0] line_offset = '0;
    logic [crtcm_pkg::CNT_W-1:0] line_column = '0;
    logic [15:0]                 tick = '0;
    int                          src_wait = 0;
    int                          sink_wait = 0;
    bit                          hold_done = 1'b0;
    int                          idle_cycles = 0;
    int                          fail_count = 0;
    int                          cells_checked = 0;
    int                          chars_mapped = 0;
    int                          wide_chars = 0;
    int                          blank_chars = 0;
    int                          pinned_cells = 0;

    char_to_terminal_cell_mapper_core DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic logic [crtcm_pkg::CNT_W-1:0] bump(
        input logic [crtcm_pkg::CNT_W-1:0] v);
        return (v >= crtcm_pkg::COUNT_MAX) ? crtcm_pkg::COUNT_MAX : v + 1'b1;
    endfunction

    function automatic bit in_zero_width(input logic [crtcm_pkg::CP_W-1:0] c);
        for (int k = 0; k < NZW; k++) begin
            if (c >= ZW_SPANS[k][41:21] && c <= ZW_SPANS[k][20:0]) return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic [1:0] char_cells(input logic [crtcm_pkg::CP_W-1:0] c);
        if (c < 'h20 || (c >= 'h7f && c < 'ha0) || in_zero_width(c)) begin
            return crtcm_pkg::WIDTH_NONE;
        end
        if (c >= 'h1100 &&
            (c <= 'h115f || c == 'h2329 || c == 'h232a ||
             (c >= 'h2e80 && c <= 'ha4cf && c != 'h303f) ||
             (c >= 'hac00 && c <= 'hd7a3) || (c >= 'hf900 && c <= 'hfaff) ||
             (c >= 'hfe30 && c <= 'hfe6f) || (c >= 'hff00 && c <= 'hff60) ||
             (c >= 'hffe0 && c <= 'hffe6) || (c >= 'h20000 && c <= 'h2fffd) ||
             (c >= 'h30000 && c <= 'h3fffd)))
            return crtcm_pkg::WIDTH_TWO;
        return crtcm_pkg::WIDTH_ONE;
    endfunction

    function automatic logic [crtcm_pkg::CP_W-1:0] rand_wide();
        case ($urandom_range(0, 9))
            0: return crtcm_pkg::CP_W'($urandom_range('h1100, 'h115f));
            1: return crtcm_pkg::CP_W'($urandom_range('h2329, 'h232a));
            2: return crtcm_pkg::CP_W'($urandom_range('h2e80, 'ha4cf));
            3: return crtcm_pkg::CP_W'($urandom_range('hac00, 'hd7a3));
            4: return crtcm_pkg::CP_W'($urandom_range('hf900, 'hfaff));
            5: return crtcm_pkg::CP_W'($urandom_range('hfe30, 'hfe6f));
            6: return crtcm_pkg::CP_W'($urandom_range('hff00, 'hff60));
            7: return crtcm_pkg::CP_W'($urandom_range('hffe0, 'hffe6));
            8: return crtcm_pkg::CP_W'($urandom_range('h20000, 'h2fffd));
            default: return crtcm_pkg::CP_W'($urandom_range('h30000, 'h3fffd));
        endcase
    endfunction

    function automatic logic [crtcm_pkg::CP_W-1:0] rand_zero_width();
        int k;
        k = $urandom_range(0, NZW - 1);
        return crtcm_pkg::CP_W'($urandom_range(ZW_SPANS[k][41:21], ZW_SPANS[k][20:0]));
    endfunction

    function automatic logic [crtcm_pkg::CP_W-1:0] rand_code();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 15) return crtcm_pkg::CP_W'($urandom_range('h20, 'h7e));
        else if (pick < 28) return crtcm_pkg::CP_W'($urandom_range('ha0, 'h2ff));
        else if (pick < 45) return rand_wide();
        else if (pick < 55) return rand_zero_width();
        else if (pick < 60) return crtcm_pkg::CP_W'($urandom_range(0, 'h1f));
        else if (pick < 63) return crtcm_pkg::CP_W'($urandom_range('h7f, 'h9f));
        else if (pick < 80) return crtcm_pkg::CP_W'($urandom);
        else if (pick < 85) return crtcm_pkg::CP_W'($urandom_range('hd800, 'hdfff));
        return EDGE_CODES[$urandom_range(0, NEDGE - 1)];
    endfunction

    function automatic bit calm_now();
        return (feed_q.size() < TAIL_WORDS) || tick[7];
    endfunction

    task automatic add_char(input logic [crtcm_pkg::CP_W-1:0] code, input logic sol,
                            input bit drain = 1'b0);
        char_word_t w;
        w.code  = code;
        w.sol   = sol;
        w.drain = drain;
        feed_q.push_back(w);
    endtask

    task automatic map_char(input logic [crtcm_pkg::CP_W-1:0] code, input logic sol);
        logic [1:0]   cells;
        screen_cell_t e;
        if (sol) begin
            line_offset = '0;
            line_column = '0;
        end
        cells = char_cells(code);
        chars_mapped++;
        if (cells == crtcm_pkg::WIDTH_NONE) begin
            blank_chars++;
        end else begin
            e.offset = line_offset;
            e.column = line_column;
            e.cont   = 1'b0;
            e.last   = (cells == crtcm_pkg::WIDTH_ONE);
            cell_q.push_back(e);
            line_column = bump(line_column);
            if (cells == crtcm_pkg::WIDTH_TWO) begin
                wide_chars++;
                e.column = line_column;
                e.cont   = 1'b1;
                e.last   = 1'b1;
                cell_q.push_back(e);
                line_column = bump(line_column);
            end
        end
        line_offset = bump(line_offset);
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            fail_count++;
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    task automatic check_cell();
        screen_cell_t want;
        cells_checked++;
        if (cell_q.size() == 0) begin
            fail_count++;
            $display("%0t: cell word expected none actual offset %0d column %0d",
                     $time, m_tdata[crtcm_pkg::CNT_W-1:0],
                     m_tdata[2*crtcm_pkg::CNT_W-1:crtcm_pkg::CNT_W]);
        end else begin
            want = cell_q.pop_front();
            check_field("source_offset", want.offset, m_tdata[crtcm_pkg::CNT_W-1:0]);
            check_field("cell_column", want.column,
                        m_tdata[2*crtcm_pkg::CNT_W-1:crtcm_pkg::CNT_W]);
            check_field("continuation", want.cont, m_tuser);
            check_field("last_entry", want.last, m_tlast);
            if (want.column == crtcm_pkg::COUNT_MAX) pinned_cells++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            src_wait <= 0;
        end else if (!s_tvalid || s_tready) begin
            if (src_wait != 0) begin
                s_tvalid <= 1'b0;
                src_wait <= src_wait - 1;
            end else if (feed_q.size() == 0 ||
                         (feed_q[0].drain && (s_tvalid || cell_q.size() != 0))) begin
                s_tvalid <= 1'b0;
            end else if (!calm_now() && $urandom_range(0, 5) == 0) begin
                s_tvalid <= 1'b0;
                src_wait <= $urandom_range(0, 11);
            end else begin
                s_tvalid <= 1'b1;
                s_tdata  <= crtcm_pkg::S_TDATA_W'(feed_q[0].code);
                s_tuser  <= feed_q[0].sol;
                feed_q.pop_front();
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            sink_wait <= 0;
            hold_done <= 1'b0;
        end else if (sink_wait != 0) begin
            m_tready  <= 1'b0;
            sink_wait <= sink_wait - 1;
        end else if (!hold_done && cells_checked >= 60) begin
            m_tready  <= 1'b0;
            sink_wait <= LONG_HOLD - 1;
            hold_done <= 1'b1;
        end else if (!calm_now() && $urandom_range(0, 6) == 0) begin
            m_tready  <= 1'b0;
            sink_wait <= $urandom_range(0, 11);
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            line_offset = '0;
            line_column = '0;
        end else begin
            if (m_tvalid && m_tready) check_cell();
            if (s_tvalid && s_tready) map_char(s_tdata[crtcm_pkg::CP_W-1:0], s_tuser);
        end
    end

    always @(posedge aclk) begin
        tick <= tick + 1'b1;
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles == STALL_LIMIT) begin
            $display("%0t: no word moved for %0d cycles, %0d words unsent, %0d cells outstanding",
                     $time, STALL_LIMIT, feed_q.size(), cell_q.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        int base;
        int pick;
        int len;

        add_char('h00041, 1'b0);
        add_char('h00000, 1'b1);
        add_char('h0001F, 1'b0);
        add_char('h00020, 1'b0);
        add_char('h0007E, 1'b0);
        add_char('h0007F, 1'b0);
        add_char('h0009F, 1'b0);
        add_char('h000A0, 1'b0);
        add_char('h00300, 1'b0);
        add_char('h01100, 1'b0);
        add_char('h0115F, 1'b0);
        add_char('h0303F, 1'b0);
        add_char('h0AC00, 1'b0);
        add_char('h0D7A3, 1'b0);
        add_char('h0FF60, 1'b0);
        add_char('h20000, 1'b0);
        add_char('h3FFFD, 1'b0);
        add_char('h0D800, 1'b0);
        add_char('h10FFFF, 1'b0);
        add_char('h110000, 1'b0);
        add_char('h1FFFFF, 1'b0);
        add_char('hE01EF, 1'b0);
        add_char('h1D167, 1'b0);
        add_char('h0FF00, 1'b1);

        // well-formed lines mostly, some noise and drained pauses
        base = feed_q.size();
        add_char(rand_code(), 1'b1, 1'b1);
        while (feed_q.size() - base < 400) begin
            pick = $urandom_range(0, 19);
            if (pick < 14) begin
                len = $urandom_range(1, 40);
                add_char(rand_code(), 1'b1);
                repeat (len - 1) add_char(rand_code(), 1'b0);
            end else if (pick < 19) begin
                repeat ($urandom_range(1, 6)) add_char(rand_code(), 1'($urandom_range(0, 1)));
            end else begin
                add_char(rand_code(), 1'($urandom_range(0, 1)), 1'b1);
            end
        end

        add_char(rand_code(), 1'b1, 1'b1);
        repeat (3) begin
            add_char(rand_code(), 1'b1);
            repeat (19) add_char(rand_code(), 1'b0);
        end

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        do begin
            @(posedge aclk);
        end while (feed_q.size() != 0 || s_tvalid || cell_q.size() != 0);
        repeat (8) @(posedge aclk);

        $display("mapped %0d characters (%0d wide, %0d zero-width) into %0d checked cells",
                 chars_mapped, wide_chars, blank_chars, cells_checked);
        $display("%0d cells at the saturated column; receiver held off %0d cycles in one stretch",
                 pinned_cells, LONG_HOLD);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

[files.f]
design/crtcm_pkg.sv
design/crtcm_front.sv
design/crtcm_fifo.sv
design/crtcm_back.sv
design/char_to_terminal_cell_mapper_core.sv
design/crtcm_checker.sv
bench/char_to_terminal_cell_mapper_core_test.sv
